// ===== rtl/layer_norm_row_macros.svh =====
// Assertion macros shared by the layer_norm_row checker.
// Needs clk and rst_n in the scope of each use.
`ifndef LAYER_NORM_ROW_MACROS_SVH
`define LAYER_NORM_ROW_MACROS_SVH

// same-cycle implication
`define LNR_CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LNR_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lnr_pkg.sv =====
// Package for layer_norm_row: sequencer states and fixed constants.
// No dependencies.
package lnr_pkg;

  // quotient register width of the shared divider
  localparam int QW = 34;
  // iteration counts per divide kind
  localparam int K_MEAN = 17;
  localparam int K_VAR  = 34;
  localparam int K_TERM = 19;
  // magnitude that saturates any normalized term
  localparam int TERM_CLAMP_BIT = 18;
  localparam int SQRT_BITS = 21;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_MEAN,
    ST_MEAN_W,
    ST_V_RD,
    ST_V_DEV,
    ST_V_SQ,
    ST_V_ACC,
    ST_N2,
    ST_N3,
    ST_V_DIV,
    ST_V_W,
    ST_SQ_STEP,
    ST_SQ_FIX,
    ST_DEN,
    ST_E_RD,
    ST_E_DEV,
    ST_E_MUL,
    ST_E_DIV,
    ST_E_W,
    ST_E_OUT
  } lnr_state_t;

endpackage

// ===== rtl/lnr_if.sv =====
// Channel interfaces of layer_norm_row: input, result and config write.
// Depends on nothing.
interface lnr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_value;
  logic signed [15:0] scale;
  logic signed [15:0] shift;
  logic               row_end;
  modport source (output valid, x_value, scale, shift, row_end, input ready);
  modport sink   (input valid, x_value, scale, shift, row_end, output ready);
endinterface

interface lnr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] norm_value;
  logic signed [15:0] row_mean;
  logic        [15:0] row_std;
  logic               run_end;
  modport source (output valid, norm_value, row_mean, row_std, run_end, input ready);
  modport sink   (input valid, norm_value, row_mean, row_std, run_end, output ready);
endinterface

interface lnr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] epsilon;
  modport source (output valid, epsilon, input ready);
  modport sink   (input valid, epsilon, output ready);
endinterface

// ===== rtl/layer_norm_row.sv =====
// Layer normalization of one row, fixed point (Q8.8 data, Q4.12 gain).
// Uses lnr_pkg and the channel interfaces in lnr_if.sv.
//
// Usage:
//  in_ch  : one request per element (x_value, scale, shift, row_end).
//           Taken one per cycle while a row loads; row_end or the
//           MAX_CHANNELS-th element closes the row.
//  out_ch : one request per stored element, in arrival order, with the
//           row mean and std; run_end marks the last one.
//  cfg_ch : epsilon write, always ready; write only while idle.
// After a row of n elements closes, the sequencer runs in order:
//  mean divide, variance pass, n^3 and variance divide, square root,
//  then one result per element, each term divided on the single shared
//  radix-2 divider unless the std is zero or the term saturates.
//  No input is taken meanwhile.
// Reset empties the row and sets epsilon to 1; row memory is not cleared.
// A stalled receiver holds the output register and the sequencer waits.
module layer_norm_row #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lnr_in_if.sink    in_ch,
  lnr_out_if.source out_ch,
  lnr_cfg_if.sink   cfg_ch
);
  import lnr_pkg::*;

  localparam int CW   = $clog2(MAX_CHANNELS + 1);
  localparam int AW   = $clog2(MAX_CHANNELS);
  localparam int SUMW = CW + 16;
  localparam int DW   = CW + 17;
  localparam int SQW  = 2 * DW;
  localparam int ACCW = 3 * CW + 34;
  localparam int NUMW = ACCW + 1;
  localparam int PW   = DW + 16;
  localparam int DENW = (3 * CW > CW + 20) ? 3 * CW : CW + 20;
  localparam int SHW  = $clog2(NUMW + 1);
  localparam int VW   = 34;
  localparam int BW   = $clog2(SQRT_BITS);

  lnr_state_t state_r, state_nxt;

  // row memory: {x, scale, shift}
  logic [47:0] mem [MAX_CHANNELS];
  logic [47:0] mem_q_r;

  logic [15:0]           eps_r;
  logic [CW-1:0]         count_r;
  logic signed [SUMW-1:0] sum_r;
  logic [CW-1:0]         idx_r;
  logic signed [15:0]    mean_r;
  logic signed [DW-1:0]  d_r;
  logic [SQW-1:0]        sq_r;
  logic [ACCW-1:0]       acc_r;
  logic [2*CW-1:0]       nn_r;
  logic [3*CW-1:0]       n3_r;
  logic [VW-1:0]         w_r;
  logic [SQRT_BITS-1:0]  root_r;
  logic [BW-1:0]         bit_r;
  logic [15:0]           sd_r;
  logic [DENW-1:0]       den_r;
  logic signed [15:0]    g_r, b_r;
  logic signed [PW-1:0]  p_r;
  logic                  tneg_r;
  logic [TERM_CLAMP_BIT:0] tmag_r;

  // output register
  logic               out_valid_r;
  logic signed [15:0] out_norm_r;
  logic               out_end_r;

  // shared divider
  logic              div_start, div_busy_r;
  logic [NUMW-1:0]   div_mag;
  logic [DENW-1:0]   div_den;
  logic [5:0]        div_k;
  logic [DENW-1:0]   rem_r, den_q_r;
  logic [NUMW-1:0]   sh_r;
  logic [QW-1:0]     q_r;
  logic [5:0]        cnt_r;
  logic [DENW:0]     div_t;
  logic              div_ge;
  logic [SHW-1:0]    sh_amt;

  logic in_fire, out_fire, out_free, last_idx, row_close;
  logic signed [15:0] mx, mg, mb;
  logic signed [DW-1:0] dev;
  logic signed [SQW-1:0] dsq;
  logic [SUMW-1:0]  smag;
  logic [PW-1:0]    pmag;
  logic [NUMW-1:0]  tnum;
  logic             tclamp;
  logic [SQRT_BITS-1:0] root_try;
  logic [2*SQRT_BITS-1:0] try_sq, root_sq, root_diff;
  logic [SQRT_BITS:0] root_fix;
  logic signed [TERM_CLAMP_BIT+1:0] term;
  logic signed [TERM_CLAMP_BIT+2:0] ysum;
  logic signed [15:0] ysat;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_valid_r && out_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign last_idx  = (idx_r == count_r - CW'(1));
  assign row_close = in_ch.row_end || (count_r == CW'(MAX_CHANNELS - 1));

  assign in_ch.ready       = (state_r == ST_LOAD);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.norm_value = out_norm_r;
  assign out_ch.row_mean   = mean_r;
  assign out_ch.row_std    = sd_r;
  assign out_ch.run_end    = out_end_r;

  assign mx  = mem_q_r[47:32];
  assign mg  = mem_q_r[31:16];
  assign mb  = mem_q_r[15:0];
  assign dev = DW'($signed({1'b0, count_r}) * mx) - DW'(sum_r);
  assign dsq = d_r * d_r;

  assign smag = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
  assign pmag = p_r[PW-1] ? PW'(-p_r) : PW'(p_r);
  assign tnum = NUMW'(pmag) + NUMW'(den_r >> 1);
  assign tclamp = tnum >= (NUMW'(den_r) << TERM_CLAMP_BIT);

  assign root_try = root_r | (SQRT_BITS'(1) << bit_r);
  assign try_sq   = (2*SQRT_BITS)'(root_try) * (2*SQRT_BITS)'(root_try);
  assign root_sq  = (2*SQRT_BITS)'(root_r) * (2*SQRT_BITS)'(root_r);
  assign root_diff = (2*SQRT_BITS)'(w_r) - root_sq;
  assign root_fix = (root_diff > (2*SQRT_BITS)'(root_r)) ?
                    {1'b0, root_r} + (SQRT_BITS+1)'(1) : {1'b0, root_r};

  assign term = tneg_r ? -$signed({1'b0, tmag_r}) : $signed({1'b0, tmag_r});
  assign ysum = (TERM_CLAMP_BIT+3)'(term) + (TERM_CLAMP_BIT+3)'(b_r);
  assign ysat = (ysum > (TERM_CLAMP_BIT+3)'(32767)) ? 16'sd32767 :
                (ysum < -(TERM_CLAMP_BIT+3)'(32768)) ? -16'sd32768 : 16'(ysum);

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_mag   = NUMW'(smag) + NUMW'(count_r >> 1);
    div_den   = DENW'(count_r);
    div_k     = 6'(K_MEAN);
    unique case (state_r)
      ST_MEAN: div_start = 1'b1;
      ST_V_DIV: begin
        div_start = 1'b1;
        div_mag   = NUMW'(acc_r) + NUMW'(n3_r >> 1);
        div_den   = DENW'(n3_r);
        div_k     = 6'(K_VAR);
      end
      ST_E_DIV: begin
        div_start = (sd_r != 16'd0) && !tclamp;
        div_mag   = tnum;
        div_den   = den_r;
        div_k     = 6'(K_TERM);
      end
      default: ;
    endcase
  end

  assign sh_amt = SHW'(NUMW) - SHW'(div_k);
  assign div_t  = {rem_r, sh_r[NUMW-1]};
  assign div_ge = div_t >= {1'b0, den_q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      cnt_r      <= '0;
    end else if (div_start) begin
      div_busy_r <= 1'b1;
      cnt_r      <= div_k;
    end else if (div_busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      rem_r   <= DENW'(div_mag >> div_k);
      sh_r    <= div_mag << sh_amt;
      q_r     <= '0;
      den_q_r <= div_den;
    end else if (div_busy_r) begin
      rem_r <= div_ge ? DENW'(div_t - {1'b0, den_q_r}) : DENW'(div_t);
      sh_r  <= sh_r << 1;
      q_r   <= {q_r[QW-2:0], div_ge};
    end
  end

  // row memory
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[count_r[AW-1:0]] <= {in_ch.x_value, in_ch.scale, in_ch.shift};
    end
    mem_q_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // mean and std feed the output, so a new row waits for the last result to drain
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:    if (in_fire && row_close) state_nxt = ST_MEAN;
      ST_MEAN:    state_nxt = ST_MEAN_W;
      ST_MEAN_W:  if (!div_busy_r && !out_valid_r) state_nxt = ST_V_RD;
      ST_V_RD:    state_nxt = ST_V_DEV;
      ST_V_DEV:   state_nxt = ST_V_SQ;
      ST_V_SQ:    state_nxt = ST_V_ACC;
      ST_V_ACC:   state_nxt = last_idx ? ST_N2 : ST_V_RD;
      ST_N2:      state_nxt = ST_N3;
      ST_N3:      state_nxt = ST_V_DIV;
      ST_V_DIV:   state_nxt = ST_V_W;
      ST_V_W:     if (!div_busy_r) state_nxt = ST_SQ_STEP;
      ST_SQ_STEP: if (bit_r == BW'(0)) state_nxt = ST_SQ_FIX;
      ST_SQ_FIX:  state_nxt = ST_DEN;
      ST_DEN:     state_nxt = ST_E_RD;
      ST_E_RD:    state_nxt = ST_E_DEV;
      ST_E_DEV:   state_nxt = ST_E_MUL;
      ST_E_MUL:   state_nxt = ST_E_DIV;
      ST_E_DIV:   state_nxt = div_start ? ST_E_W : ST_E_OUT;
      ST_E_W:     if (!div_busy_r) state_nxt = ST_E_OUT;
      ST_E_OUT: begin
        if (out_free) state_nxt = last_idx ? ST_LOAD : ST_E_RD;
      end
      default:    state_nxt = ST_LOAD;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r       <= 16'd1;
      count_r     <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        eps_r <= cfg_ch.epsilon;
      end
      if (in_fire) begin
        count_r <= count_r + CW'(1);
        sum_r   <= sum_r + SUMW'(in_ch.x_value);
      end
      if (out_fire && state_r != ST_E_OUT) begin
        out_valid_r <= 1'b0;
      end
      priority case (state_r)
        ST_V_ACC: idx_r <= last_idx ? '0 : idx_r + CW'(1);
        ST_E_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (last_idx) begin
              idx_r   <= '0;
              count_r <= '0;
              sum_r   <= '0;
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_MEAN: acc_r <= '0;
      ST_MEAN_W: begin
        if (!div_busy_r && !out_valid_r) begin
          mean_r <= sum_r[SUMW-1] ? -$signed(q_r[15:0]) : $signed(q_r[15:0]);
        end
      end
      ST_V_DEV: d_r <= dev;
      ST_V_SQ:  sq_r <= $unsigned(dsq);
      ST_V_ACC: acc_r <= acc_r + ACCW'(sq_r);
      ST_N2:    nn_r <= (2*CW)'(count_r) * (2*CW)'(count_r);
      ST_N3:    n3_r <= (3*CW)'(nn_r) * (3*CW)'(count_r);
      ST_V_W: begin
        w_r    <= VW'(q_r) + VW'(eps_r);
        root_r <= '0;
        bit_r  <= BW'(SQRT_BITS - 1);
      end
      ST_SQ_STEP: begin
        if (try_sq <= (2*SQRT_BITS)'(w_r)) begin
          root_r <= root_try;
        end
        bit_r <= bit_r - BW'(1);
      end
      ST_SQ_FIX: sd_r <= (root_fix > (SQRT_BITS+1)'(65535)) ? 16'hFFFF : root_fix[15:0];
      ST_DEN: den_r <= DENW'({(CW+16)'(count_r) * (CW+16)'(sd_r), 4'b0000});
      ST_E_DEV: begin
        d_r <= dev;
        g_r <= mg;
        b_r <= mb;
      end
      ST_E_MUL: p_r <= PW'(g_r * d_r);
      ST_E_DIV: begin
        tneg_r <= p_r[PW-1];
        if (sd_r == 16'd0) begin
          tmag_r <= '0;
        end else if (tclamp) begin
          tmag_r <= (TERM_CLAMP_BIT+1)'(1) << TERM_CLAMP_BIT;
        end
      end
      ST_E_W: if (!div_busy_r) tmag_r <= q_r[TERM_CLAMP_BIT:0];
      ST_E_OUT: begin
        if (out_free) begin
          out_norm_r <= ysat;
          out_end_r  <= last_idx;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/lnr_checker.sv =====
// Port-level checks for layer_norm_row, bound into layer_norm_row.
// Uses layer_norm_row_macros.svh.
`include "layer_norm_row_macros.svh"

module lnr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_row_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_run_end,
  input logic [15:0] out_norm_value
);

  // a row closed by row_end blocks new requests
  `LNR_CHK_NXT(a_close_blocks, in_valid && in_ready && in_row_end, !in_ready, "input taken after row close")

  // results other than the last of a row only appear while input is held off
  `LNR_CHK_IMP(a_emit_no_load, out_valid && !out_run_end, !in_ready, "input open mid-row emit")

  // a stalled result holds
  `LNR_CHK_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_norm_value), "stalled result changed")

endmodule

bind layer_norm_row lnr_checker u_lnr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_row_end     (in_ch.row_end),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_run_end    (out_ch.run_end),
  .out_norm_value (out_ch.norm_value)
);

// ===== sim/lnr_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from rtl/lnr_if.sv.
// This file only holds the small package of stimulus helpers' types.
// Depends on nothing.
package lnr_tb_pkg;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] scale;
    logic signed [15:0] shift;
    logic               row_end;
  } elem_req_t;

  typedef struct packed {
    logic signed [15:0] norm_value;
    logic signed [15:0] row_mean;
    logic        [15:0] row_std;
    logic               run_end;
  } norm_res_t;

endpackage

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for layer_norm_row: drives rows of elements, predicts each row's
// normalized outputs, mean and std in fixed point and checks them. Needs lnr_tb_pkg, lnr_if.sv.
module testbench;
  import lnr_tb_pkg::*;

  localparam int MAXC = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lnr_in_if  in_ch();
  lnr_out_if out_ch();
  lnr_cfg_if cfg_ch();

  layer_norm_row #(.MAX_CHANNELS(MAXC)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  elem_req_t pending_reqs[$];
  norm_res_t expected_norms[$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_cycles = 0;
  int        hold_remaining = 0;

  // predictor state
  logic [15:0]        eps_reg;
  logic signed [15:0] row_x[MAXC];
  logic signed [15:0] row_g[MAXC];
  logic signed [15:0] row_b[MAXC];
  int                 row_cnt;
  longint             row_sum;

  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint isqrt_round(longint w);
    longint r;
    longint t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= w) r = t;
    end
    if (w - r * r > r) r++;
    return r;
  endfunction

  // accept one element into the row model; push results when the row closes
  task automatic predict_element(elem_req_t e);
    longint    d, sumsq, n3, sd, mean, term, y;
    int        n;
    norm_res_t r;
    row_x[row_cnt] = e.x_value;
    row_g[row_cnt] = e.scale;
    row_b[row_cnt] = e.shift;
    row_sum += e.x_value;
    row_cnt++;
    if (!e.row_end && row_cnt < MAXC) return;
    n = row_cnt;
    mean = round_div(row_sum, n);
    sumsq = 0;
    for (int i = 0; i < n; i++) begin
      d = longint'(n) * row_x[i] - row_sum;
      sumsq += d * d;
    end
    n3 = longint'(n) * n * n;
    sd = isqrt_round((sumsq + n3 / 2) / n3 + eps_reg);
    if (sd > 65535) sd = 65535;
    for (int i = 0; i < n; i++) begin
      d = longint'(n) * row_x[i] - row_sum;
      term = (sd != 0) ? round_div(longint'(row_g[i]) * d, 16 * n * sd) : 0;
      y = term + row_b[i];
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      r.norm_value = y[15:0];
      r.row_mean = mean[15:0];
      r.row_std = sd[15:0];
      r.run_end = (i == n - 1);
      expected_norms.push_back(r);
    end
    row_cnt = 0;
    row_sum = 0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.x_value <= '0;
      in_ch.scale <= '0;
      in_ch.shift <= '0;
      in_ch.row_end <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_element({in_ch.x_value, in_ch.scale, in_ch.shift, in_ch.row_end});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          elem_req_t e;
          e = pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.x_value <= e.x_value;
          in_ch.scale <= e.scale;
          in_ch.shift <= e.shift;
          in_ch.row_end <= e.row_end;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_remaining <= 0;
    end else if (hold_cycles > 0 && hold_remaining == 0) begin
      hold_remaining <= hold_cycles;
      out_ch.ready <= 1'b0;
    end else if (hold_remaining > 1) begin
      hold_remaining <= hold_remaining - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_remaining == 1) hold_remaining <= -1;
      out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_norms.size() == 0) begin
        $error("unexpected result norm_value=%0d", out_ch.norm_value);
        fail_count++;
      end else begin
        norm_res_t x;
        x = expected_norms.pop_front();
        if (out_ch.norm_value !== x.norm_value) begin
          $error("norm_value exp %0d got %0d", x.norm_value, out_ch.norm_value);
          fail_count++;
        end
        if (out_ch.row_mean !== x.row_mean) begin
          $error("row_mean exp %0d got %0d", x.row_mean, out_ch.row_mean);
          fail_count++;
        end
        if (out_ch.row_std !== x.row_std) begin
          $error("row_std exp %0d got %0d", x.row_std, out_ch.row_std);
          fail_count++;
        end
        if (out_ch.run_end !== x.run_end) begin
          $error("run_end exp %0d got %0d", x.run_end, out_ch.run_end);
          fail_count++;
        end
      end
    end
  end

  task automatic add_elem(int xv, int g, int b, bit last);
    elem_req_t e;
    e.x_value = xv[15:0];
    e.scale = g[15:0];
    e.shift = b[15:0];
    e.row_end = last;
    pending_reqs.push_back(e);
  endtask

  task automatic add_random_row(int len);
    int mode;
    int base;
    mode = $urandom_range(3, 0);
    base = $urandom_range(65535, 0) - 32768;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: add_elem($urandom_range(65535, 0), $urandom_range(65535, 0),
                    $urandom_range(65535, 0), i == len - 1);
        1: add_elem(base + $urandom_range(8, 0) - 4, $urandom_range(65535, 0),
                    $urandom_range(65535, 0), i == len - 1);
        default: add_elem($urandom_range(1023, 0) - 512, $urandom_range(8191, 0) - 4096,
                          $urandom_range(2047, 0) - 1024, i == len - 1);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_norms.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.epsilon <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    eps_reg = v;
  endtask

  task automatic run_phase(int s_idle, int r_idle, int n_items);
    int left;
    int len;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(MAXC, 20) : $urandom_range(8, 1);
      if (len > left) len = left;
      add_random_row(len);
      left -= len;
    end
    wait_drained();
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.epsilon = '0;
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    eps_reg = 16'd1;
    row_cnt = 0;
    row_sum = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single element, extremes, constant row
    add_elem(32767, 32767, -32768, 1'b1);
    add_elem(-32768, -32768, 32767, 1'b0);
    add_elem(32767, 32767, 0, 1'b1);
    add_elem(100, 4096, 5, 1'b0);
    add_elem(100, -4096, -5, 1'b0);
    add_elem(100, 0, 0, 1'b1);
    add_elem(-1, 32767, 1, 1'b0);
    add_elem(1, -32768, -1, 1'b1);
    wait_drained();

    // zero std when epsilon is 0
    write_epsilon(16'd0);
    add_elem(256, 4096, 77, 1'b0);
    add_elem(256, -4096, -77, 1'b1);
    // full buffer closes the row despite no end mark
    for (int i = 0; i < MAXC; i++)
      add_elem((i * 997) - 30000, 4096 + i, i, 1'b0);
    add_elem(5, 4096, 0, 1'b1);
    wait_drained();

    write_epsilon(16'hFFFF);
    run_phase(32, 70, 45);
    write_epsilon(16'd1);
    run_phase(70, 32, 45);

    // long receiver hold-off while sender keeps offering
    write_epsilon(16'd300);
    hold_cycles = 3000;
    run_phase(0, 0, 45);
    hold_cycles = 0;

    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
